// ===== design/hta_pkg.sv =====
package hta_pkg;

    // operation codes (stream tuser on the slave side)
    localparam logic [1:0] MODE_LOOKUP   = 2'd0;
    localparam logic [1:0] MODE_UPDATE   = 2'd1;
    localparam logic [1:0] MODE_ALLOCATE = 2'd2;

    // result status codes (stream tuser on the master side)
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam int WORD_W = 32;

    // what every cell of the row does in a cycle
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_ROT   = 2'd1;
    localparam logic [1:0] OP_SORT  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       phase;   // odd-even pairing phase during OP_SORT
    } cell_ctrl_t;

endpackage

// ===== design/handle_table_allocator.sv =====
// Sequence: lookup and update rotate the cell row once (the scan), then register the result;
// allocate appends directly, and when the table is full it first runs a count rotation,
// then odd-even exchange rounds, before the append.
// Throughput: one word in flight; the next is taken once the result is in the output
// register. Reset: synchronous active-low aresetn clears control, fill count to zero,
// next handle to one; table cells are not reset.
module handle_table_allocator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] handle_id, [63:32] data_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] data_out, [63:32] new_handle
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int W     = hta_pkg::WORD_W;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_SORT   = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [W-1:0]     hid_reg, hid_next;
    logic [W-1:0]     dval_reg, dval_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [W-1:0]     next_handle_reg, next_handle_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [W-1:0]     res_dout_reg, res_dout_next;
    logic [W-1:0]     res_nh_reg, res_nh_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [W-1:0]     m_dout_reg, m_dout_next;
    logic [W-1:0]     m_nh_reg, m_nh_next;

    hta_pkg::cell_ctrl_t ctrl;
    logic [W-1:0] cell_h [TABLE_DEPTH];
    logic [W-1:0] cell_d [TABLE_DEPTH];
    logic [W-1:0] wrap_h, wrap_d;
    logic         hit;
    logic         in_fire;

    assign in_fire = s_tvalid && s_tready;
    // cell 0 holds the entry whose index equals the rotation count
    assign hit = cell_h[0] == hid_reg && CNT_W'(cnt_reg) < fill_reg && !found_reg;

    always_comb begin
        wrap_h = cell_h[0];
        wrap_d = cell_d[0];
        if (state_reg == S_SCAN && mode_reg == hta_pkg::MODE_UPDATE && hit) begin
            wrap_d = dval_reg;
        end
    end

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        hid_next         = hid_reg;
        dval_next        = dval_reg;
        cnt_next         = cnt_reg;
        found_next       = found_reg;
        fill_next        = fill_reg;
        kept_next        = kept_reg;
        next_handle_next = next_handle_reg;
        res_status_next  = res_status_reg;
        res_dout_next    = res_dout_reg;
        res_nh_next      = res_nh_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_dout_next      = m_dout_reg;
        m_nh_next        = m_nh_reg;
        ctrl.op          = hta_pkg::OP_HOLD;
        ctrl.phase       = cnt_reg[0];

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    mode_next       = s_tuser;
                    hid_next        = s_tdata[31:0];
                    dval_next       = s_tdata[63:32];
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    kept_next       = '0;
                    res_status_next = hta_pkg::ST_OK;
                    res_dout_next   = '0;
                    res_nh_next     = '0;
                    case (s_tuser)
                        hta_pkg::MODE_LOOKUP:   state_next = S_SCAN;
                        hta_pkg::MODE_UPDATE:   state_next = S_SCAN;
                        hta_pkg::MODE_ALLOCATE: begin
                            state_next = (fill_reg == FULL_CNT) ? S_COUNT : S_APPEND;
                        end
                        default:                state_next = S_WAIT;
                    endcase
                end
            end
            S_SCAN: begin
                ctrl.op  = hta_pkg::OP_ROT;
                cnt_next = cnt_reg + 1'b1;
                if (hit) begin
                    found_next = 1'b1;
                    if (mode_reg == hta_pkg::MODE_LOOKUP) begin
                        res_dout_next = cell_d[0];
                    end
                end
                if (cnt_reg == LAST_IDX) begin
                    cnt_next        = '0;
                    res_status_next = (found_reg || hit) ? hta_pkg::ST_OK
                                                         : hta_pkg::ST_NOT_FOUND;
                    state_next      = S_WAIT;
                end
            end
            S_COUNT: begin
                ctrl.op  = hta_pkg::OP_ROT;
                cnt_next = cnt_reg + 1'b1;
                if (cell_d[0] != '0) begin
                    kept_next = kept_reg + 1'b1;
                end
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    fill_next  = (cell_d[0] != '0) ? kept_reg + 1'b1 : kept_reg;
                    state_next = S_SORT;
                end
            end
            S_SORT: begin
                // odd-even exchange: free slots drift up, live entries keep order
                ctrl.op  = hta_pkg::OP_SORT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = S_APPEND;
                end
            end
            S_APPEND: begin
                if (fill_reg == FULL_CNT) begin
                    res_status_next = hta_pkg::ST_FULL;
                end else begin
                    ctrl.op          = hta_pkg::OP_WRITE;
                    fill_next        = fill_reg + 1'b1;
                    res_nh_next      = next_handle_reg;
                    next_handle_next = next_handle_reg + 1'b1;
                end
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_dout_next   = res_dout_reg;
                    m_nh_next     = res_nh_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            next_handle_reg <= W'(1);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            next_handle_reg <= next_handle_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        hid_reg        <= hid_next;
        dval_reg       <= dval_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        kept_reg       <= kept_next;
        res_status_reg <= res_status_next;
        res_dout_reg   <= res_dout_next;
        res_nh_reg     <= res_nh_next;
        m_status_reg   <= m_status_next;
        m_dout_reg     <= m_dout_next;
        m_nh_reg       <= m_nh_next;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [W-1:0] lh, ld, rh, rd;
        if (i == 0) begin : g_first
            assign lh = '0;
            assign ld = '0;
        end else begin : g_mid_l
            assign lh = cell_h[i-1];
            assign ld = cell_d[i-1];
        end
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign rh = wrap_h;
            assign rd = wrap_d;
        end else begin : g_mid_r
            assign rh = cell_h[i+1];
            assign rd = cell_d[i+1];
        end
        hta_cell #(
            .IDX     (i),
            .CNT_W   (CNT_W),
            .IS_LAST (i == TABLE_DEPTH - 1)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .fill         (fill_reg),
            .left_handle  (lh),
            .left_data    (ld),
            .right_handle (rh),
            .right_data   (rd),
            .wr_handle    (next_handle_reg),
            .wr_data      (dval_reg),
            .handle       (cell_h[i]),
            .data         (cell_d[i])
        );
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_nh_reg, m_dout_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== design/hta_cell.sv =====
// One table slot. Rotates toward cell 0, takes part in an odd-even exchange
// that moves free slots (zero data) toward the end, or loads the append word.
module hta_cell #(
    parameter int IDX     = 0,
    parameter int CNT_W   = 7,
    parameter bit IS_LAST = 1'b0
) (
    input  logic                      aclk,
    input  hta_pkg::cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]          fill,
    input  logic [hta_pkg::WORD_W-1:0] left_handle,
    input  logic [hta_pkg::WORD_W-1:0] left_data,
    input  logic [hta_pkg::WORD_W-1:0] right_handle,
    input  logic [hta_pkg::WORD_W-1:0] right_data,
    input  logic [hta_pkg::WORD_W-1:0] wr_handle,
    input  logic [hta_pkg::WORD_W-1:0] wr_data,
    output logic [hta_pkg::WORD_W-1:0] handle,
    output logic [hta_pkg::WORD_W-1:0] data
);

    localparam bit               IS_FIRST = (IDX == 0);
    localparam bit               ODD      = (IDX % 2) == 1;
    localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(IDX);

    logic [hta_pkg::WORD_W-1:0] handle_reg, handle_next;
    logic [hta_pkg::WORD_W-1:0] data_reg, data_next;

    always_comb begin
        handle_next = handle_reg;
        data_next   = data_reg;
        case (ctrl.op)
            hta_pkg::OP_ROT: begin
                handle_next = right_handle;
                data_next   = right_data;
            end
            hta_pkg::OP_SORT: begin
                if (ODD == ctrl.phase) begin
                    // left member of the pair
                    if (!IS_LAST && data_reg == '0 && right_data != '0) begin
                        handle_next = right_handle;
                        data_next   = right_data;
                    end
                end else begin
                    // right member of the pair
                    if (!IS_FIRST && left_data == '0 && data_reg != '0) begin
                        handle_next = left_handle;
                        data_next   = left_data;
                    end
                end
            end
            hta_pkg::OP_WRITE: begin
                if (fill == MY_POS) begin
                    handle_next = wr_handle;
                    data_next   = wr_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        handle_reg <= handle_next;
        data_reg   <= data_next;
    end

    assign handle = handle_reg;
    assign data   = data_reg;

endmodule

// ===== design/hta_checker.sv =====
module hta_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: accept closes the input until the result is done
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == hta_pkg::ST_OK || m_tuser == hta_pkg::ST_NOT_FOUND
                     || m_tuser == hta_pkg::ST_FULL)
        else $error("bad status code");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hta_pkg::ST_NOT_FOUND |-> m_tdata == 64'd0)
        else $error("not-found result carries data");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hta_pkg::ST_FULL |-> m_tdata == 64'd0)
        else $error("full result carries data or handle");

endmodule

bind handle_table_allocator hta_checker u_hta_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/handle_table_allocator_test.sv =====
module handle_table_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1350;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_out;
        logic [31:0] new_handle;
    } reply_t;

    // shadow copy of the handle table; predicts one reply per accepted word
    class handle_table_mirror;
        logic [31:0] handles [TABLE_DEPTH];
        logic [31:0] data [TABLE_DEPTH];
        int unsigned fill;
        logic [31:0] next_h;
        reply_t      replies [$];
        int          errors;

        function new();
            fill = 0;
            next_h = 32'd1;
            errors = 0;
        endfunction

        function int find_slot(logic [31:0] h);
            for (int i = 0; i < fill; i++) begin
                if (handles[i] == h) return i;
            end
            return -1;
        endfunction

        // keep live entries in order, drop freed ones
        function void compact();
            int unsigned w;
            w = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (data[i] != 32'd0) begin
                    handles[w] = handles[i];
                    data[w] = data[i];
                    w++;
                end
            end
            fill = w;
        endfunction

        function void note_request(logic [1:0] mode, logic [31:0] hid, logic [31:0] dval);
            reply_t r;
            int     slot;
            r = '0;
            r.status = hta_pkg::ST_OK;
            case (mode)
                hta_pkg::MODE_LOOKUP: begin
                    slot = find_slot(hid);
                    if (slot < 0) r.status = hta_pkg::ST_NOT_FOUND;
                    else r.data_out = data[slot];
                end
                hta_pkg::MODE_UPDATE: begin
                    slot = find_slot(hid);
                    if (slot < 0) r.status = hta_pkg::ST_NOT_FOUND;
                    else data[slot] = dval;
                end
                hta_pkg::MODE_ALLOCATE: begin
                    if (fill >= TABLE_DEPTH) compact();
                    if (fill >= TABLE_DEPTH) begin
                        r.status = hta_pkg::ST_FULL;
                    end else begin
                        handles[fill] = next_h;
                        data[fill] = dval;
                        fill++;
                        r.new_handle = next_h;
                        next_h = next_h + 32'd1;
                    end
                end
                default: ;
            endcase
            replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] status, logic [31:0] dout, logic [31:0] nh);
            reply_t r;
            if (replies.size() == 0) begin
                $display("%0t: unexpected word, status %h data_out %h new_handle %h",
                         $time, status, dout, nh);
                errors++;
                return;
            end
            r = replies.pop_front();
            if (status !== r.status) begin
                $display("%0t: status expected %h actual %h", $time, r.status, status);
                errors++;
            end
            if (dout !== r.data_out) begin
                $display("%0t: data_out expected %h actual %h", $time, r.data_out, dout);
                errors++;
            end
            if (nh !== r.new_handle) begin
                $display("%0t: new_handle expected %h actual %h", $time, r.new_handle, nh);
                errors++;
            end
        endfunction

        function int pending();
            return replies.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // [31:0] handle_id, [63:32] data_value
    logic [1:0]  s_tuser = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // [31:0] data_out, [63:32] new_handle
    logic [1:0]  m_tuser;        // [1:0] status

    handle_table_mirror mirror = new();

    int unsigned items_sent = 0;
    int unsigned allocs_sent = 0;
    int          burst_left = 0;
    int          hold_requests = 0;
    int          holds_done = 0;

    handle_table_allocator #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("handle_table_allocator_test: errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) mirror.note_request(s_tuser, s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready) mirror.check_reply(m_tuser, m_tdata[31:0], m_tdata[63:32]);
        end
    end

    // receiver: short ready/stall runs, occasional long ready stretch, one long hold on request
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(50, 300)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic [31:0] hid,
                             input logic [31:0] dval);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {dval, hid};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        while (mirror.pending() != 0) @(posedge aclk);
    endtask

    // one word plus the sender's burst/gap pattern
    task automatic issue(input logic [1:0] mode, input logic [31:0] hid,
                         input logic [31:0] dval);
        send_word(mode, hid, dval);
        if (mode == hta_pkg::MODE_ALLOCATE) allocs_sent++;
        if (mode != MODE_UNUSED) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // a handle that was probably handed out recently
    function automatic logic [31:0] known_handle();
        int unsigned lo;
        if (allocs_sent == 0) return $urandom;
        lo = (allocs_sent > 80) ? allocs_sent - 80 : 1;
        return $urandom_range(allocs_sent, lo);
    endfunction

    function automatic logic [31:0] live_data();
        logic [31:0] v;
        v = $urandom;
        if (v == 32'd0) v = 32'd1;
        return v;
    endfunction

    initial begin
        int          round;
        int          kind;
        int          n;
        int          pick;
        logic [31:0] h;
        round = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, freed entries, unused mode
        issue(hta_pkg::MODE_LOOKUP, 32'd1, 32'd0);
        issue(hta_pkg::MODE_UPDATE, 32'd0, 32'hFFFF_FFFF);
        issue(hta_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(hta_pkg::MODE_ALLOCATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(hta_pkg::MODE_ALLOCATE, 32'd0, 32'd0);
        issue(hta_pkg::MODE_LOOKUP, 32'd1, 32'd0);
        issue(hta_pkg::MODE_LOOKUP, 32'd2, 32'd0);       // found, data zero
        issue(hta_pkg::MODE_UPDATE, 32'd1, 32'h1234_5678);
        issue(hta_pkg::MODE_LOOKUP, 32'd1, 32'hFFFF_FFFF);
        issue(hta_pkg::MODE_UPDATE, 32'd1, 32'd0);       // free it
        issue(hta_pkg::MODE_LOOKUP, 32'd1, 32'd0);
        issue(hta_pkg::MODE_UPDATE, 32'd3, 32'd5);       // not allocated yet
        issue(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(MODE_UNUSED, 32'd0, 32'd0);
        issue(hta_pkg::MODE_ALLOCATE, 32'h5A5A_5A5A, 32'd1);
        issue(hta_pkg::MODE_UPDATE, 32'd2, 32'h8000_0000);
        issue(hta_pkg::MODE_LOOKUP, 32'd2, 32'd0);
        issue(hta_pkg::MODE_LOOKUP, 32'd3, 32'd0);
        issue(hta_pkg::MODE_LOOKUP, 32'd0, 32'd0);
        issue(hta_pkg::MODE_LOOKUP, 32'h8000_0000, 32'd0);
        idle(1);
        drain();

        while (items_sent < ITEM_TARGET) begin
            round++;
            kind = $urandom_range(0, 10);
            if (round == 1) kind = 10;          // saturate early: compaction and full table
            if (round == 3) hold_requests++;    // receiver backs up while we keep sending
            case (kind)
                0, 1, 2, 3: begin
                    // fill burst, mostly live data, some lookups in between
                    n = $urandom_range(40, 90);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0)
                            issue(hta_pkg::MODE_LOOKUP, known_handle(), $urandom);
                        else
                            issue(hta_pkg::MODE_ALLOCATE, $urandom,
                                  ($urandom_range(0, 7) == 0) ? 32'd0 : live_data());
                    end
                end
                4, 5, 6, 7: begin
                    n = $urandom_range(20, 60);
                    repeat (n) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 35)
                            issue(hta_pkg::MODE_LOOKUP, known_handle(), $urandom);
                        else if (pick < 65)
                            issue(hta_pkg::MODE_UPDATE, known_handle(),
                                  ($urandom_range(0, 4) < 2) ? 32'd0 : live_data());
                        else if (pick < 75)
                            issue(hta_pkg::MODE_LOOKUP, $urandom, $urandom);
                        else if (pick < 80)
                            issue(hta_pkg::MODE_UPDATE, $urandom, $urandom);
                        else if (pick < 95)
                            issue(hta_pkg::MODE_ALLOCATE, $urandom,
                                  ($urandom_range(0, 3) == 0) ? 32'd0 : live_data());
                        else
                            issue(MODE_UNUSED, $urandom, $urandom);
                    end
                end
                8: begin
                    n = $urandom_range(10, 30);
                    repeat (n) issue(2'($urandom_range(0, 3)), $urandom, $urandom);
                end
                9: begin
                    // free a run of recent handles so the next compaction has work
                    n = $urandom_range(20, 64);
                    h = (allocs_sent > 63) ? allocs_sent - 63 : 1;
                    repeat (n) begin
                        issue(hta_pkg::MODE_UPDATE, h, 32'd0);
                        h++;
                    end
                end
                default: begin
                    n = $urandom_range(66, 80);
                    repeat (n) issue(hta_pkg::MODE_ALLOCATE, $urandom, live_data());
                end
            endcase
            if (round == 2 || $urandom_range(0, 3) == 0) begin
                idle(1);
                drain();
            end
        end

        idle(1);
        drain();
        repeat (2 * TABLE_DEPTH + 8) @(posedge aclk);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("handle_table_allocator_test: clean");
        else
            $display("handle_table_allocator_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/hta_pkg.sv
design/hta_cell.sv
design/handle_table_allocator.sv
design/hta_checker.sv
bench/handle_table_allocator_test.sv
